// ===== rtl/r2bap_pkg.sv =====
// shared types and constants for the resp2 bulk/array stream parser
// no dependencies
package r2bap_pkg;

	// protocol characters
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_MINUS  = 8'h2D;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_LF     = 8'h0A;

	// result kinds
	localparam logic [1:0] KIND_DATA = 2'd0;
	localparam logic [1:0] KIND_END  = 2'd1;
	localparam logic [1:0] KIND_ERR  = 2'd2;

	// error codes
	localparam logic [2:0] ERR_NO_MARK   = 3'd0;
	localparam logic [2:0] ERR_BAD_LEN   = 3'd1;
	localparam logic [2:0] ERR_NULL_BULK = 3'd2;
	localparam logic [2:0] ERR_TOO_LONG  = 3'd3;
	localparam logic [2:0] ERR_NO_CRLF   = 3'd4;
	localparam logic [2:0] ERR_BAD_ALEN  = 3'd5;
	localparam logic [2:0] ERR_ARR_RANGE = 3'd6;
	localparam logic [2:0] ERR_BAD_TYPE  = 3'd7;

	localparam int unsigned DEF_MAX_ELEMENTS = 1024;
	localparam logic [31:0] MAX_BULK_LEN_RST = 32'd536870912;
	localparam int unsigned ACC_W = 33;

	// header character class
	typedef enum logic [1:0] {
		LC_MORE,
		LC_CR,
		LC_BAD
	} len_class_t;

	typedef struct packed {
		logic clr;
		logic step;
	} len_ctl_t;

	typedef struct packed {
		len_class_t       cls;
		logic [ACC_W-1:0] acc;
		logic             minus;
		logic             too_big;
	} len_stat_t;

endpackage

// ===== rtl/r2bap_len_acc.sv =====
// length header scanner: sign, decimal accumulator with saturation flag
// depends on r2bap_pkg
module r2bap_len_acc (
	input  logic                 clk,
	input  logic                 arst_n,
	input  r2bap_pkg::len_ctl_t  ctl,
	input  logic [7:0]           in_byte,
	output r2bap_pkg::len_stat_t stat
);
	import r2bap_pkg::*;

	logic [ACC_W-1:0] acc_q;
	logic             minus_q;
	logic             digit_q;
	logic             too_big_q;
	logic             is_digit;
	logic             is_minus;
	logic [ACC_W+3:0] acc_x10;

	assign is_digit = (in_byte >= CH_ZERO) && (in_byte <= CH_NINE);
	assign is_minus = (in_byte == CH_MINUS) && !minus_q && !digit_q;
	// acc*10 + digit, four spare bits catch overflow
	assign acc_x10 = {1'b0, acc_q, 3'b000} + {3'b000, acc_q, 1'b0}
		+ {{ACC_W{1'b0}}, in_byte[3:0]};

	always_comb begin
		stat.acc     = acc_q;
		stat.minus   = minus_q;
		stat.too_big = too_big_q;
		if (is_minus || is_digit) begin
			stat.cls = LC_MORE;
		end else if (in_byte == CH_CR && digit_q) begin
			stat.cls = LC_CR;
		end else begin
			stat.cls = LC_BAD;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q     <= '0;
			minus_q   <= 1'b0;
			digit_q   <= 1'b0;
			too_big_q <= 1'b0;
		end else if (ctl.clr) begin
			acc_q     <= '0;
			minus_q   <= 1'b0;
			digit_q   <= 1'b0;
			too_big_q <= 1'b0;
		end else if (ctl.step) begin
			if (is_minus) begin
				minus_q <= 1'b1;
			end else if (is_digit) begin
				digit_q <= 1'b1;
				if (!too_big_q) begin
					if (acc_x10[ACC_W+3:ACC_W] != 4'd0) begin
						too_big_q <= 1'b1;
					end else begin
						acc_q <= acc_x10[ACC_W-1:0];
					end
				end
			end
		end
	end

endmodule

// ===== rtl/resp2_bulk_array_parser_top.sv =====
// resp2 bulk string / bulk array stream parser, top level
// depends on r2bap_pkg and r2bap_len_acc
// result word: registered, valid in the cycle after its input word is accepted
// throughput: one input word per cycle while no result waits on a stalled output;
// the parse state and the result register both update at the input handshake
// reset (arst_n low) returns to idle awaiting a type byte, clears the halt
// flag and the output register, and loads max_bulk_len with 536870912
module resp2_bulk_array_parser_top #(
	parameter int unsigned MAX_ELEMENTS = r2bap_pkg::DEF_MAX_ELEMENTS
) (
	input  logic        clk,
	input  logic        arst_n,
	// configuration write channel (max_bulk_len)
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [31:0] cfg_data,
	// input byte stream
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	// result stream
	output logic        out_valid,
	input  logic        out_ready,
	output logic [1:0]  kind,
	output logic [7:0]  data_byte,
	output logic [9:0]  element_index,
	output logic        frame_done,
	output logic        from_array,
	output logic [2:0]  error_code
);
	import r2bap_pkg::*;

	// width of the remaining-elements counter, able to hold MAX_ELEMENTS
	localparam int unsigned EW = $clog2(MAX_ELEMENTS + 1);
	localparam logic [ACC_W-1:0] MAX_EL_ACC = ACC_W'(MAX_ELEMENTS);

	typedef enum logic [3:0] {
		PH_IDLE,
		PH_MARK,
		PH_BLEN,
		PH_BLEN_LF,
		PH_BODY,
		PH_BODY_CR,
		PH_BODY_LF,
		PH_ALEN,
		PH_ALEN_LF
	} phase_t;

	phase_t      phase_q, phase_d;
	logic [31:0] max_len_q;
	logic [31:0] body_rem_q, body_rem_d;
	logic [EW-1:0] el_rem_q, el_rem_d;
	logic [9:0]  cur_el_q, cur_el_d;
	logic        array_q, array_d;
	logic        halted_q, halted_d;

	// result being formed this cycle
	logic        res_vld;
	logic [1:0]  res_kind;
	logic [7:0]  res_byte;
	logic [9:0]  res_idx;
	logic        res_done;
	logic        res_arr;
	logic [2:0]  res_code;

	logic        in_fire;
	len_ctl_t    len_ctl;
	len_stat_t   len_st;

	// the output register frees up as it is taken, so input never waits
	// on an empty or draining result slot
	assign in_ready  = !out_valid || out_ready;
	assign in_fire   = in_valid && in_ready;
	assign cfg_ready = 1'b1;

	// header scanner is cleared on a type or element marker byte and
	// stepped on every header byte
	assign len_ctl.clr  = in_fire && !halted_q &&
		(phase_q == PH_IDLE || phase_q == PH_MARK);
	assign len_ctl.step = in_fire && !halted_q &&
		(phase_q == PH_BLEN || phase_q == PH_ALEN);

	r2bap_len_acc u_len (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (len_ctl),
		.in_byte (in_byte),
		.stat    (len_st)
	);

	// next-state and result decode for one byte
	always_comb begin
		phase_d    = phase_q;
		body_rem_d = body_rem_q;
		el_rem_d   = el_rem_q;
		cur_el_d   = cur_el_q;
		array_d    = array_q;
		halted_d   = halted_q;
		res_vld    = 1'b0;
		res_kind   = KIND_ERR;
		res_byte   = 8'd0;
		res_done   = 1'b0;
		res_code   = ERR_NO_MARK;

		if (!halted_q) begin
			unique case (phase_q)
				PH_IDLE: begin
					cur_el_d = 10'd0;
					el_rem_d = '0;
					if (in_byte == CH_DOLLAR) begin
						array_d = 1'b0;
						phase_d = PH_BLEN;
					end else if (in_byte == CH_STAR) begin
						array_d = 1'b1;
						phase_d = PH_ALEN;
					end else begin
						array_d  = 1'b0;
						res_vld  = 1'b1;
						res_code = ERR_BAD_TYPE;
					end
				end
				PH_MARK: begin
					if (in_byte == CH_DOLLAR) begin
						phase_d = PH_BLEN;
					end else begin
						res_vld  = 1'b1;
						res_code = ERR_NO_MARK;
					end
				end
				PH_BLEN: begin
					if (len_st.cls == LC_BAD) begin
						res_vld  = 1'b1;
						res_code = ERR_BAD_LEN;
					end else if (len_st.cls == LC_CR) begin
						phase_d = PH_BLEN_LF;
					end
				end
				PH_BLEN_LF: begin
					if (in_byte != CH_LF) begin
						res_vld  = 1'b1;
						res_code = ERR_BAD_LEN;
					end else if (len_st.minus && (len_st.acc != '0 || len_st.too_big)) begin
						// negative length other than minus zero
						res_vld  = 1'b1;
						res_code = ERR_NULL_BULK;
					end else if (len_st.too_big || len_st.acc > {1'b0, max_len_q}) begin
						res_vld  = 1'b1;
						res_code = ERR_TOO_LONG;
					end else begin
						body_rem_d = len_st.acc[31:0];
						phase_d    = (len_st.acc[31:0] != 32'd0) ? PH_BODY : PH_BODY_CR;
					end
				end
				PH_BODY: begin
					res_vld    = 1'b1;
					res_kind   = KIND_DATA;
					res_byte   = in_byte;
					res_code   = 3'd0;
					body_rem_d = body_rem_q - 32'd1;
					if (body_rem_q == 32'd1) begin
						phase_d = PH_BODY_CR;
					end
				end
				PH_BODY_CR: begin
					if (in_byte != CH_CR) begin
						res_vld  = 1'b1;
						res_code = ERR_NO_CRLF;
					end else begin
						phase_d = PH_BODY_LF;
					end
				end
				PH_BODY_LF: begin
					res_vld = 1'b1;
					if (in_byte != CH_LF) begin
						res_code = ERR_NO_CRLF;
					end else begin
						// element end, and frame end on the last one
						res_kind = KIND_END;
						res_code = 3'd0;
						if (!array_q || el_rem_q <= EW'(1)) begin
							res_done = 1'b1;
							phase_d  = PH_IDLE;
							if (array_q) begin
								el_rem_d = '0;
							end
						end else begin
							el_rem_d = el_rem_q - EW'(1);
							cur_el_d = cur_el_q + 10'd1;
							phase_d  = PH_MARK;
						end
					end
				end
				PH_ALEN: begin
					if (len_st.cls == LC_BAD) begin
						res_vld  = 1'b1;
						res_code = ERR_BAD_ALEN;
					end else if (len_st.cls == LC_CR) begin
						phase_d = PH_ALEN_LF;
					end
				end
				PH_ALEN_LF: begin
					if (in_byte != CH_LF) begin
						res_vld  = 1'b1;
						res_code = ERR_BAD_ALEN;
					end else if (len_st.too_big || (len_st.minus && len_st.acc != '0) ||
						len_st.acc > MAX_EL_ACC) begin
						res_vld  = 1'b1;
						res_code = ERR_ARR_RANGE;
					end else begin
						cur_el_d = 10'd0;
						if (len_st.acc == '0) begin
							// empty array ends at its header
							res_vld  = 1'b1;
							res_kind = KIND_END;
							res_code = 3'd0;
							res_done = 1'b1;
							phase_d  = PH_IDLE;
						end else begin
							el_rem_d = len_st.acc[EW-1:0];
							phase_d  = PH_MARK;
						end
					end
				end
				default: begin
					phase_d = PH_IDLE;
				end
			endcase
			if (res_vld && res_kind == KIND_ERR) begin
				halted_d = 1'b1;
			end
		end
		// element index and array flag are taken after the idle-phase updates
		res_idx = (phase_q == PH_IDLE) ? 10'd0 : cur_el_q;
		res_arr = (phase_q == PH_IDLE) ? array_d : array_q;
	end

	// state and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_IDLE;
			body_rem_q    <= 32'd0;
			el_rem_q      <= '0;
			cur_el_q      <= 10'd0;
			array_q       <= 1'b0;
			halted_q      <= 1'b0;
			out_valid     <= 1'b0;
			kind          <= KIND_DATA;
			data_byte     <= 8'd0;
			element_index <= 10'd0;
			frame_done    <= 1'b0;
			from_array    <= 1'b0;
			error_code    <= 3'd0;
		end else begin
			if (in_fire) begin
				phase_q    <= phase_d;
				body_rem_q <= body_rem_d;
				el_rem_q   <= el_rem_d;
				cur_el_q   <= cur_el_d;
				array_q    <= array_d;
				halted_q   <= halted_d;
			end
			if (in_fire && res_vld) begin
				out_valid     <= 1'b1;
				kind          <= res_kind;
				data_byte     <= res_byte;
				element_index <= res_idx;
				frame_done    <= res_done;
				from_array    <= res_arr;
				error_code    <= res_code;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	// max_bulk_len register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_len_q <= MAX_BULK_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			max_len_q <= cfg_data;
		end
	end

`ifndef SYNTHESIS
	// once halted, the parser stays halted until reset
	a_halt_sticky: assert property (@(posedge clk) disable iff (!arst_n)
		halted_q |=> halted_q)
		else $error("halt flag cleared without reset");

	// an error word is the last word ever produced
	a_err_last: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_ready && kind == KIND_ERR) |=> !out_valid)
		else $error("result after error");

	// frame completion only on an element end word
	a_done_kind: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && frame_done) |-> (kind == KIND_END && error_code == 3'd0))
		else $error("frame_done on a non element-end word");

	// a pending error word always comes with the halt flag set
	a_err_halt: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && kind == KIND_ERR) |-> halted_q)
		else $error("error word without halt");
`endif

endmodule

// ===== verif/resp2_bulk_array_parser_top_test.sv =====
// self-checking testbench for resp2_bulk_array_parser_top: byte stream in, result words out
// depends on r2bap_pkg and the parser rtl; carries its own parser model to predict results
// one run ends on a single injected protocol fault, since the parser halts until reset
module resp2_bulk_array_parser_top_test;
	import r2bap_pkg::*;

	// one result word as the parser presents it
	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] data;
		logic [9:0] index;
		logic       done;
		logic       arr;
		logic [2:0] code;
	} result_word_t;

	// where the model parser stands in the frame
	typedef enum logic [3:0] {
		P_IDLE,
		P_MARK,
		P_BLEN,
		P_BLEN_LF,
		P_BODY,
		P_BODY_CR,
		P_BODY_LF,
		P_ALEN,
		P_ALEN_LF
	} parse_phase_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [31:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [1:0]  kind;
	logic [7:0]  data_byte;
	logic [9:0]  element_index;
	logic        frame_done;
	logic        from_array;
	logic [2:0]  error_code;

	resp2_bulk_array_parser_top u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.in_byte       (in_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.kind          (kind),
		.data_byte     (data_byte),
		.element_index (element_index),
		.frame_done    (frame_done),
		.from_array    (from_array),
		.error_code    (error_code)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// stream bytes still to be offered, and result words the model says must come
	logic [7:0]   pending_bytes[$];
	result_word_t awaited_words[$];
	int unsigned  errors = 0;
	int unsigned  bytes_taken = 0;

	// model parser state, reset values as after arst_n
	logic [31:0]  bulk_limit = MAX_BULK_LEN_RST;
	parse_phase_t ph = P_IDLE;
	logic [32:0]  hdr_acc = '0;
	logic         hdr_minus = 1'b0;
	logic         hdr_digit = 1'b0;
	logic         hdr_big = 1'b0;
	logic [31:0]  body_left = '0;
	logic [10:0]  elems_left = '0;
	logic [10:0]  elem_no = '0;
	logic         in_array = 1'b0;
	logic         halted = 1'b0;

	function automatic void clear_header();
		hdr_acc = '0;
		hdr_minus = 1'b0;
		hdr_digit = 1'b0;
		hdr_big = 1'b0;
	endfunction

	// one header character: optional leading minus, digits, then cr
	// the accumulator freezes and flags once it would pass 33 bits
	function automatic len_class_t header_char(input logic [7:0] c);
		logic [36:0] grown;
		if (c == CH_MINUS && !hdr_minus && !hdr_digit) begin
			hdr_minus = 1'b1;
			return LC_MORE;
		end
		if (c >= CH_ZERO && c <= CH_NINE) begin
			hdr_digit = 1'b1;
			if (!hdr_big) begin
				grown = 37'(hdr_acc) * 37'd10 + 37'(c - CH_ZERO);
				if (grown > 37'h1_FFFF_FFFF)
					hdr_big = 1'b1;
				else
					hdr_acc = grown[32:0];
			end
			return LC_MORE;
		end
		if (c == CH_CR && hdr_digit)
			return LC_CR;
		return LC_BAD;
	endfunction

	function automatic result_word_t make_word(input logic [1:0] k, input logic [7:0] d,
			input logic done);
		result_word_t w;
		w.kind = k;
		w.data = d;
		w.index = elem_no[9:0];
		w.done = done;
		w.arr = in_array;
		w.code = '0;
		return w;
	endfunction

	// first violation: one error word, then silence until reset
	function automatic result_word_t fault_word(input logic [2:0] code);
		result_word_t w;
		halted = 1'b1;
		w = make_word(KIND_ERR, 8'd0, 1'b0);
		w.code = code;
		return w;
	endfunction

	// advance the model by one stream byte; returns 1 when a result word is due
	function automatic bit parse_byte(input logic [7:0] c, output result_word_t w);
		len_class_t cls;
		logic       last;
		w = '0;
		if (halted)
			return 1'b0;
		case (ph)
			P_IDLE: begin
				elem_no = '0;
				elems_left = '0;
				clear_header();
				if (c == CH_DOLLAR) begin
					in_array = 1'b0;
					ph = P_BLEN;
					return 1'b0;
				end
				if (c == CH_STAR) begin
					in_array = 1'b1;
					ph = P_ALEN;
					return 1'b0;
				end
				in_array = 1'b0;
				w = fault_word(ERR_BAD_TYPE);
				return 1'b1;
			end
			P_MARK: begin
				clear_header();
				if (c == CH_DOLLAR) begin
					ph = P_BLEN;
					return 1'b0;
				end
				w = fault_word(ERR_NO_MARK);
				return 1'b1;
			end
			P_BLEN: begin
				cls = header_char(c);
				if (cls == LC_BAD) begin
					w = fault_word(ERR_BAD_LEN);
					return 1'b1;
				end
				if (cls == LC_CR)
					ph = P_BLEN_LF;
				return 1'b0;
			end
			P_BLEN_LF: begin
				if (c != CH_LF) begin
					w = fault_word(ERR_BAD_LEN);
					return 1'b1;
				end
				// "-0" is a plain empty string, any other negative is null
				if (hdr_minus && (hdr_acc != 0 || hdr_big)) begin
					w = fault_word(ERR_NULL_BULK);
					return 1'b1;
				end
				if (hdr_big || hdr_acc > {1'b0, bulk_limit}) begin
					w = fault_word(ERR_TOO_LONG);
					return 1'b1;
				end
				body_left = hdr_acc[31:0];
				ph = (body_left != 0) ? P_BODY : P_BODY_CR;
				return 1'b0;
			end
			P_BODY: begin
				w = make_word(KIND_DATA, c, 1'b0);
				body_left = body_left - 1;
				if (body_left == 0)
					ph = P_BODY_CR;
				return 1'b1;
			end
			P_BODY_CR: begin
				if (c != CH_CR) begin
					w = fault_word(ERR_NO_CRLF);
					return 1'b1;
				end
				ph = P_BODY_LF;
				return 1'b0;
			end
			P_BODY_LF: begin
				if (c != CH_LF) begin
					w = fault_word(ERR_NO_CRLF);
					return 1'b1;
				end
				if (in_array) begin
					last = (elems_left <= 1);
					w = make_word(KIND_END, 8'd0, last);
					if (last) begin
						elems_left = '0;
						ph = P_IDLE;
					end else begin
						elems_left = elems_left - 1;
						elem_no = elem_no + 1;
						ph = P_MARK;
					end
				end else begin
					w = make_word(KIND_END, 8'd0, 1'b1);
					ph = P_IDLE;
				end
				return 1'b1;
			end
			P_ALEN: begin
				cls = header_char(c);
				if (cls == LC_BAD) begin
					w = fault_word(ERR_BAD_ALEN);
					return 1'b1;
				end
				if (cls == LC_CR)
					ph = P_ALEN_LF;
				return 1'b0;
			end
			P_ALEN_LF: begin
				if (c != CH_LF) begin
					w = fault_word(ERR_BAD_ALEN);
					return 1'b1;
				end
				if (hdr_big || (hdr_minus && hdr_acc != 0) || hdr_acc > 33'(DEF_MAX_ELEMENTS)) begin
					w = fault_word(ERR_ARR_RANGE);
					return 1'b1;
				end
				elem_no = '0;
				// an empty array ends right at its header
				if (hdr_acc == 0) begin
					w = make_word(KIND_END, 8'd0, 1'b1);
					ph = P_IDLE;
					return 1'b1;
				end
				elems_left = hdr_acc[10:0];
				ph = P_MARK;
				return 1'b0;
			end
			default: begin
				ph = P_IDLE;
				return 1'b0;
			end
		endcase
	endfunction

	// ---------------- stream building ----------------

	task automatic put_crlf();
		pending_bytes.push_back(CH_CR);
		pending_bytes.push_back(CH_LF);
	endtask

	task automatic put_text(input string s);
		int i;
		for (i = 0; i < s.len(); i++)
			pending_bytes.push_back(s[i]);
	endtask

	task automatic put_number(input logic [63:0] n);
		logic [7:0]  digs[$];
		logic [63:0] v;
		v = n;
		do begin
			digs.push_front(CH_ZERO + 8'(v % 10));
			v = v / 10;
		end while (v != 0);
		foreach (digs[k])
			pending_bytes.push_back(digs[k]);
	endtask

	// header with the odd legal forms mixed in: "-0" and leading zeros
	task automatic put_header(input logic [7:0] marker, input logic [63:0] n);
		pending_bytes.push_back(marker);
		if (n == 0 && $urandom_range(0, 3) == 0)
			pending_bytes.push_back(CH_MINUS);
		if ($urandom_range(0, 5) == 0)
			repeat ($urandom_range(1, 3)) pending_bytes.push_back(CH_ZERO);
		put_number(n);
		put_crlf();
	endtask

	// well-formed bulk string, body no longer than the current limit
	task automatic put_bulk(input logic [31:0] limit);
		int unsigned cap;
		int unsigned len;
		cap = (limit < 24) ? limit : 24;
		if ($urandom_range(0, 3) == 0)
			len = $urandom_range(0, cap);
		else
			len = $urandom_range(0, (cap < 4) ? cap : 4);
		put_header(CH_DOLLAR, len);
		// bodies carry protocol characters too, they must pass as data
		repeat (len) begin
			case ($urandom_range(0, 9))
				0: pending_bytes.push_back(CH_CR);
				1: pending_bytes.push_back(CH_LF);
				2: pending_bytes.push_back(CH_DOLLAR);
				3: pending_bytes.push_back(CH_STAR);
				default: pending_bytes.push_back(8'($urandom_range(0, 255)));
			endcase
		end
		put_crlf();
	endtask

	task automatic put_frame(input logic [31:0] limit);
		int unsigned count;
		if ($urandom_range(0, 4) < 2) begin
			put_bulk(limit);
		end else begin
			if ($urandom_range(0, 7) == 0)
				count = 0;
			else if ($urandom_range(0, 9) == 0)
				count = $urandom_range(7, 20);
			else
				count = $urandom_range(1, 4);
			put_header(CH_STAR, count);
			repeat (count) put_bulk(limit);
		end
	endtask

	// one broken sequence aimed at a random error, then trailing noise the parser must ignore
	task automatic put_fault();
		logic [2:0] aim;
		logic [7:0] junk;
		aim = 3'($urandom_range(0, 7));
		case (aim)
			ERR_NO_MARK: begin
				put_header(CH_STAR, 2);
				put_header(CH_DOLLAR, 0);
				put_crlf();
				junk = 8'($urandom_range(0, 255));
				if (junk == CH_DOLLAR)
					junk = CH_STAR;
				pending_bytes.push_back(junk);
			end
			ERR_BAD_LEN: begin
				case ($urandom_range(0, 3))
					0: put_text("$\r");
					1: put_text("$1\rA");
					2: put_text("$3-");
					default: put_text("$-x");
				endcase
			end
			ERR_NULL_BULK: begin
				put_text("$-");
				if ($urandom_range(0, 1) == 0)
					put_number($urandom_range(1, 1000));
				else
					put_number(64'd99999999999);
				put_crlf();
			end
			ERR_TOO_LONG: begin
				pending_bytes.push_back(CH_DOLLAR);
				case ($urandom_range(0, 2))
					0: put_number({32'd0, bulk_limit} + 64'd1);
					1: put_number(64'd4294967296);
					default: put_number(64'd99999999999);
				endcase
				put_crlf();
			end
			ERR_NO_CRLF: begin
				put_header(CH_DOLLAR, 1);
				pending_bytes.push_back(8'h51);
				if ($urandom_range(0, 1) == 0)
					pending_bytes.push_back(CH_CR);
				pending_bytes.push_back(8'h5A);
			end
			ERR_BAD_ALEN: begin
				case ($urandom_range(0, 3))
					0: put_text("*\r");
					1: put_text("*x");
					2: put_text("*1\r*");
					default: put_text("*--");
				endcase
			end
			ERR_ARR_RANGE: begin
				case ($urandom_range(0, 2))
					0: put_text("*1025\r\n");
					1: put_text("*-2\r\n");
					default: put_text("*99999999999\r\n");
				endcase
			end
			default: begin
				junk = 8'($urandom_range(0, 255));
				if (junk == CH_DOLLAR || junk == CH_STAR)
					junk = 8'h2B;
				pending_bytes.push_back(junk);
			end
		endcase
		repeat ($urandom_range(8, 24)) pending_bytes.push_back(8'($urandom_range(0, 255)));
	endtask

	// ---------------- sender ----------------

	int unsigned burst_left = 0;
	int unsigned gap_left = 0;

	// predicts at each accepted byte; payload only moves when the word is taken or none is up
	always @(posedge clk) begin
		result_word_t w;
		logic [7:0]   next_byte;
		logic         offer;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				if (parse_byte(in_byte, w))
					awaited_words.push_back(w);
				bytes_taken++;
			end
			if (!in_valid || in_ready) begin
				offer = 1'b0;
				next_byte = in_byte;
				if (gap_left != 0) begin
					gap_left--;
				end else if (pending_bytes.size() != 0) begin
					offer = 1'b1;
					next_byte = pending_bytes.pop_front();
					if (burst_left <= 1) begin
						burst_left = $urandom_range(1, 40);
						gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
					end else begin
						burst_left--;
					end
				end
				in_valid <= offer;
				in_byte <= next_byte;
			end
		end
	end

	// ---------------- receiver ----------------

	int unsigned hold_left = 0;
	bit          hold_done = 1'b0;
	int unsigned mode = 0;
	int unsigned mode_left = 0;

	// stall modes switch now and then; mode 0 never stalls
	// one long hold-off mid-run backs the parser up into its input
	always @(posedge clk) begin
		logic rdy;
		if (hold_left != 0) begin
			hold_left--;
			rdy = 1'b0;
		end else if (!hold_done && bytes_taken >= 200) begin
			hold_done = 1'b1;
			hold_left = 300;
			rdy = 1'b0;
		end else begin
			if (mode_left == 0) begin
				mode = $urandom_range(0, 3);
				mode_left = $urandom_range(20, 120);
			end else begin
				mode_left--;
			end
			case (mode)
				0: rdy = 1'b1;
				1: rdy = ($urandom_range(0, 1) == 0);
				2: rdy = ($urandom_range(0, 3) == 0);
				default: rdy = ($urandom_range(0, 3) != 0);
			endcase
		end
		out_ready <= rdy;
	end

	// ---------------- result check ----------------

	task automatic compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		result_word_t want;
		if (arst_n && out_valid && out_ready) begin
			if (awaited_words.size() == 0) begin
				$error("result word with none awaited: kind %0d data %0h code %0d",
					kind, data_byte, error_code);
				errors++;
			end else begin
				want = awaited_words.pop_front();
				compare_field("kind", want.kind, kind);
				compare_field("data_byte", want.data, data_byte);
				compare_field("element_index", want.index, element_index);
				compare_field("frame_done", want.done, frame_done);
				compare_field("from_array", want.arr, from_array);
				compare_field("error_code", want.code, error_code);
			end
		end
	end

	// ---------------- sequencing ----------------

	// all bytes taken and all awaited words in, else an error is flagged
	task automatic settle();
		int unsigned waited;
		waited = 0;
		while (pending_bytes.size() != 0 || in_valid)
			@(posedge clk);
		while (awaited_words.size() != 0 && waited < 4000) begin
			@(posedge clk);
			waited++;
		end
		repeat (4) @(posedge clk);
		if (awaited_words.size() != 0) begin
			$error("%0d awaited result words never arrived", awaited_words.size());
			errors++;
			awaited_words.delete();
		end
	endtask

	task automatic write_limit(input logic [31:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		bulk_limit = value;
	endtask

	initial begin
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;

		// directed frames under the reset limit
		put_text("$2\r\n");
		pending_bytes.push_back(8'h00);
		pending_bytes.push_back(8'hFF);
		put_crlf();
		put_text("*0\r\n");
		put_text("*-0\r\n");
		put_text("$-0\r\n\r\n");
		put_text("*3\r\n$0\r\n\r\n$1\r\n\r\r\n$2\r\n\n$\r\n");
		put_text("$00000000000000000001\r\nZ\r\n");
		settle();

		// widest limit
		write_limit(32'hFFFF_FFFF);
		while (pending_bytes.size() < 330)
			put_frame(bulk_limit);
		settle();

		// zero limit, only empty strings pass
		write_limit(32'd0);
		while (pending_bytes.size() < 150)
			put_frame(bulk_limit);
		settle();

		// tight limit
		write_limit(32'($urandom_range(1, 6)));
		while (pending_bytes.size() < 250)
			put_frame(bulk_limit);
		settle();

		// any limit, then the run ends on one protocol fault
		write_limit(32'($urandom));
		while (pending_bytes.size() < 250)
			put_frame(bulk_limit);
		put_fault();
		settle();

		repeat (8) @(posedge clk);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// hang guard, far beyond the slowest legal run
	initial begin
		#400000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

// ===== resp2_bulk_array_parser_top.f =====
rtl/r2bap_pkg.sv
rtl/r2bap_len_acc.sv
rtl/resp2_bulk_array_parser_top.sv
verif/resp2_bulk_array_parser_top_test.sv
